[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge.
`define SFRR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SFRR_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SFRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sfrr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrr_pkg
// Types and fixed constants of the serial frame register responder.
// ----------------------------------------------------------------------------
package sfrr_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int AREA_ADDR_W = 10;
  localparam int POS_W       = 9;
  localparam int TICK_W      = 10;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_ADDR   = 2'd0,
    CFG_REPLY_ADDR = 2'd1,
    CFG_TIMEOUT    = 2'd2
  } cfg_idx_t;

  localparam logic [7:0]        OWN_ADDR_RST   = 8'd34;
  localparam logic [7:0]        REPLY_ADDR_RST = 8'd37;
  localparam logic [TICK_W-1:0] TIMEOUT_RST    = 10'd100;
  localparam logic [TICK_W-1:0] TICK_MAX       = 10'd1023;

  // Frame bytes and request modes.
  localparam logic [7:0]  SYNC0            = 8'h55;
  localparam logic [7:0]  SYNC1            = 8'hAA;
  localparam logic [7:0]  MIN_LENGTH       = 8'd2;
  localparam logic [7:0]  READ_REQ_LENGTH  = 8'd3;
  localparam logic [7:0]  MODE_RD_STATUS   = 8'h01;
  localparam logic [7:0]  MODE_RD_SETTINGS = 8'hF1;
  localparam logic [7:0]  MODE_WR_STATUS   = 8'h03;
  localparam logic [7:0]  MODE_WR_SETTINGS = 8'hF3;
  localparam logic [15:0] SUM_INVERT       = 16'hFFFF;

  // Receive positions, counted from one for the first sync byte.
  localparam logic [POS_W-1:0] POS_SYNC0   = 9'd1;
  localparam logic [POS_W-1:0] POS_SYNC1   = 9'd2;
  localparam logic [POS_W-1:0] POS_LENGTH  = 9'd3;
  localparam logic [POS_W-1:0] POS_ADDR    = 9'd4;
  localparam logic [POS_W-1:0] POS_MODE    = 9'd5;
  localparam logic [POS_W-1:0] POS_OFFSET  = 9'd6;
  localparam logic [POS_W-1:0] POS_PAYLOAD = 9'd7;

  // Reply header byte indexes.
  localparam logic [2:0] HDR_SYNC0  = 3'd0;
  localparam logic [2:0] HDR_SYNC1  = 3'd1;
  localparam logic [2:0] HDR_LENGTH = 3'd2;
  localparam logic [2:0] HDR_ADDR   = 3'd3;
  localparam logic [2:0] HDR_MODE   = 3'd4;
  localparam logic [2:0] HDR_OFFSET = 3'd5;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_WR_RD,
    ST_WR_WR,
    ST_HDR,
    ST_RD,
    ST_DATA,
    ST_CSL,
    ST_CSH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    OSEL_HDR,
    OSEL_DATA,
    OSEL_CSL,
    OSEL_CSH
  } out_sel_t;

  typedef struct packed {
    logic     accept;
    logic     clear_en;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     area_wr;
    logic     out_load;
    out_sel_t out_sel;
  } sfrr_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic rx_final;
    logic go_write;
    logic go_read;
    logic cnt_last;
    logic hdr_last;
    logic out_free;
  } sfrr_status_t;

endpackage

[sv/sfrr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrr channel interfaces
// Receive, transmit and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface sfrr_rx_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface sfrr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_of_reply;

  modport source (output valid, output tx_byte, output last_of_reply, input ready);
  modport sink (input valid, input tx_byte, input last_of_reply, output ready);
endinterface

interface sfrr_cfg_if import sfrr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[sv/sfrr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrr_ctrl
// Sequencer: memory clearing, receive, frame check, area write and reply.
// ----------------------------------------------------------------------------
module sfrr_ctrl import sfrr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         rx_valid,
  output logic         rx_ready,
  input  sfrr_status_t st,
  output sfrr_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (st.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (rx_valid && st.rx_final) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (st.go_write) begin
          state_next = ST_WR_RD;
        end else if (st.go_read) begin
          state_next = ST_HDR;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WR_RD: begin
        state_next = st.cnt_last ? ST_IDLE : ST_WR_WR;
      end
      ST_WR_WR: begin
        state_next = ST_WR_RD;
      end
      ST_HDR: begin
        if (st.out_free && st.hdr_last) state_next = ST_RD;
      end
      ST_RD: begin
        state_next = st.cnt_last ? ST_CSL : ST_DATA;
      end
      ST_DATA: begin
        if (st.out_free) state_next = ST_RD;
      end
      ST_CSL: begin
        if (st.out_free) state_next = ST_CSH;
      end
      ST_CSH: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    rx_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
      end
      ST_IDLE: begin
        rx_ready   = 1'b1;
        cmd.accept = rx_valid;
      end
      ST_CHECK: begin
        cmd.cnt_clr = 1'b1;
      end
      ST_WR_WR: begin
        cmd.area_wr = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      ST_HDR: begin
        cmd.out_sel = OSEL_HDR;
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.cnt_clr  = st.hdr_last;
          cmd.cnt_inc  = !st.hdr_last;
        end
      end
      ST_DATA: begin
        cmd.out_sel = OSEL_DATA;
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.cnt_inc  = 1'b1;
        end
      end
      ST_CSL: begin
        cmd.out_sel  = OSEL_CSL;
        cmd.out_load = st.out_free;
      end
      ST_CSH: begin
        cmd.out_sel  = OSEL_CSH;
        cmd.out_load = st.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[sv/sfrr_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrr_dp
// Deframer registers, payload buffer, status and settings memories, reply
// byte assembly and the transmit output register.
// ----------------------------------------------------------------------------
module sfrr_dp import sfrr_pkg::*; #(
  parameter int MAX_PAYLOAD    = 32,
  parameter int STATUS_BYTES   = 256,
  parameter int SETTINGS_BYTES = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         func,
  input  logic [7:0]   rx_byte,
  sfrr_cfg_if.sink     cfg,
  sfrr_tx_if.source    tx,
  input  sfrr_cmd_t    cmd,
  output sfrr_status_t st
);

  localparam int PAY_AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_RAW   = $clog2(MAX_PAYLOAD + 1);
  localparam int CNT_W     = (CNT_RAW > 3) ? CNT_RAW : 3;
  localparam int STA_AW    = $clog2(STATUS_BYTES);
  localparam int SET_AW    = $clog2(SETTINGS_BYTES);
  localparam int CLR_DEPTH = (STATUS_BYTES > SETTINGS_BYTES) ? STATUS_BYTES : SETTINGS_BYTES;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  localparam logic [AREA_ADDR_W-1:0] STATUS_SIZE   = AREA_ADDR_W'(STATUS_BYTES);
  localparam logic [AREA_ADDR_W-1:0] SETTINGS_SIZE = AREA_ADDR_W'(SETTINGS_BYTES);
  localparam logic [POS_W-1:0]       MAX_PAY_V     = POS_W'(MAX_PAYLOAD);
  localparam logic [CLR_W-1:0]       CLR_LAST      = CLR_W'(CLR_DEPTH - 1);

  // Configuration registers; writes are always accepted and registered.
  logic [7:0]        own_addr;
  logic [7:0]        reply_addr;
  logic [TICK_W-1:0] timeout;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_addr   <= OWN_ADDR_RST;
      reply_addr <= REPLY_ADDR_RST;
      timeout    <= TIMEOUT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_OWN_ADDR:   own_addr   <= cfg.data[7:0];
        CFG_REPLY_ADDR: reply_addr <= cfg.data[7:0];
        CFG_TIMEOUT:    timeout    <= cfg.data[TICK_W-1:0];
        default:        ;
      endcase
    end
  end

  // Receive state.
  logic [POS_W-1:0]  frame_pos;
  logic [POS_W-1:0]  frame_pos_next;
  logic [TICK_W-1:0] elapsed;
  logic [TICK_W-1:0] elapsed_next;
  logic [7:0]        frame_length;
  logic [7:0]        frame_mode;
  logic [7:0]        frame_offset;
  logic [7:0]        read_size;
  logic [15:0]       running_sum;
  logic [15:0]       running_sum_next;
  logic [15:0]       recv_sum;

  logic [POS_W-1:0] pos_cur;
  logic [POS_W-1:0] pos_new;
  logic [POS_W-1:0] pay_idx;
  logic [POS_W-1:0] plen;
  logic             take_byte;
  logic             take_tick;
  logic             ld_length;
  logic             ld_mode;
  logic             ld_offset;
  logic             ld_size;
  logic             ld_rsum_lo;
  logic             ld_rsum_hi;
  logic             pay_we;

  assign take_byte = cmd.accept && !func;
  assign take_tick = cmd.accept && func;
  assign pos_cur   = (elapsed >= timeout) ? '0 : frame_pos;
  assign pos_new   = pos_cur + POS_W'(1);
  assign pay_idx   = pos_new - POS_PAYLOAD;
  assign plen      = {1'b0, frame_length} - POS_W'(MIN_LENGTH);

  always_comb begin
    frame_pos_next   = frame_pos;
    elapsed_next     = elapsed;
    running_sum_next = running_sum + {8'd0, rx_byte};
    ld_length        = 1'b0;
    ld_mode          = 1'b0;
    ld_offset        = 1'b0;
    ld_size          = 1'b0;
    ld_rsum_lo       = 1'b0;
    ld_rsum_hi       = 1'b0;
    pay_we           = 1'b0;
    if (take_tick && elapsed != TICK_MAX) begin
      elapsed_next = elapsed + TICK_W'(1);
    end
    if (take_byte) begin
      frame_pos_next = pos_new;
      case (pos_new)
        POS_SYNC0: begin
          if (rx_byte != SYNC0) begin
            frame_pos_next = '0;
          end else begin
            elapsed_next = '0;
          end
        end
        POS_SYNC1: begin
          if (rx_byte != SYNC1) frame_pos_next = '0;
        end
        POS_LENGTH: begin
          if (rx_byte < MIN_LENGTH) begin
            frame_pos_next = '0;
          end else begin
            ld_length        = 1'b1;
            running_sum_next = {8'd0, rx_byte};
          end
        end
        POS_ADDR: begin
          if (rx_byte != own_addr) frame_pos_next = '0;
        end
        POS_MODE: begin
          ld_mode = 1'b1;
        end
        POS_OFFSET: begin
          ld_offset = 1'b1;
        end
        default: begin
          if (pay_idx < plen) begin
            pay_we  = (pay_idx < MAX_PAY_V);
            ld_size = (pay_idx == '0);
          end else if (pay_idx == plen) begin
            ld_rsum_lo = 1'b1;
          end else begin
            ld_rsum_hi     = 1'b1;
            frame_pos_next = '0;
          end
        end
      endcase
    end
  end

  // The running sum only moves on bytes that belong to the summed span.
  logic sum_en;
  assign sum_en = take_byte && (ld_length || ld_mode || ld_offset ||
                  (pos_new == POS_ADDR && rx_byte == own_addr) ||
                  (pos_new >= POS_PAYLOAD && pay_idx < plen));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos <= '0;
      elapsed   <= '0;
    end else begin
      frame_pos <= frame_pos_next;
      elapsed   <= elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_length)  frame_length    <= rx_byte;
    if (ld_mode)    frame_mode      <= rx_byte;
    if (ld_offset)  frame_offset    <= rx_byte;
    if (ld_size)    read_size       <= rx_byte;
    if (ld_rsum_lo) recv_sum[7:0]   <= rx_byte;
    if (ld_rsum_hi) recv_sum[15:8]  <= rx_byte;
    if (sum_en)     running_sum     <= running_sum_next;
  end

  assign st.rx_final = !func && (pos_new >= POS_PAYLOAD) && (pay_idx > plen);

  // Transfer counter shared by header, data and payload copy.
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Payload buffer, read at the transfer counter.
  logic [7:0] payload_mem [MAX_PAYLOAD];
  logic [7:0] pay_rdata;

  always_ff @(posedge clk) begin
    if (pay_we) payload_mem[pay_idx[PAY_AW-1:0]] <= rx_byte;
    pay_rdata <= payload_mem[cnt[PAY_AW-1:0]];
  end

  // Request decode and bounds checks on the completed frame.
  logic                   is_status;
  logic                   is_rd;
  logic                   is_wr;
  logic                   sum_ok;
  logic                   plen_ok;
  logic                   fits;
  logic [7:0]             xfer_sz;
  logic [AREA_ADDR_W-1:0] ofs;
  logic [AREA_ADDR_W-1:0] area_size;
  logic [AREA_ADDR_W-1:0] area_addr;

  assign is_status = (frame_mode == MODE_RD_STATUS) || (frame_mode == MODE_WR_STATUS);
  assign is_rd     = (frame_mode == MODE_RD_STATUS) || (frame_mode == MODE_RD_SETTINGS);
  assign is_wr     = (frame_mode == MODE_WR_STATUS) || (frame_mode == MODE_WR_SETTINGS);
  assign sum_ok    = (running_sum ^ SUM_INVERT) == recv_sum;
  assign plen_ok   = plen <= MAX_PAY_V;
  assign area_size = is_status ? STATUS_SIZE : SETTINGS_SIZE;
  assign ofs       = {1'b0, frame_offset, 1'b0};
  assign xfer_sz   = is_wr ? plen[7:0] : read_size;
  assign fits      = (ofs + AREA_ADDR_W'(xfer_sz)) <= area_size;
  assign area_addr = ofs + AREA_ADDR_W'(cnt);

  assign st.go_write = sum_ok && plen_ok && is_wr && fits;
  assign st.go_read  = sum_ok && plen_ok && is_rd && fits &&
                       (frame_length == READ_REQ_LENGTH) &&
                       ({1'b0, read_size} <= MAX_PAY_V);
  assign st.cnt_last = 8'(cnt) == xfer_sz;
  assign st.hdr_last = cnt == CNT_W'(HDR_OFFSET);

  // Status and settings memories, cleared by a sweep after reset.
  logic [CLR_W-1:0]       clr_idx;
  logic [AREA_ADDR_W-1:0] wr_addr;
  logic [7:0]             wr_data;
  logic                   sta_we;
  logic                   set_we;
  logic [7:0]             status_mem [STATUS_BYTES];
  logic [7:0]             settings_mem [SETTINGS_BYTES];
  logic [7:0]             sta_rdata;
  logic [7:0]             set_rdata;
  logic [7:0]             area_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear_en) begin
      clr_idx <= clr_idx + CLR_W'(1);
    end
  end

  assign st.clear_last = clr_idx == CLR_LAST;
  assign wr_addr = cmd.clear_en ? AREA_ADDR_W'(clr_idx) : area_addr;
  assign wr_data = cmd.clear_en ? 8'd0 : pay_rdata;
  assign sta_we  = cmd.clear_en ? (wr_addr < STATUS_SIZE) : (cmd.area_wr && is_status);
  assign set_we  = cmd.clear_en ? (wr_addr < SETTINGS_SIZE) : (cmd.area_wr && !is_status);

  always_ff @(posedge clk) begin
    if (sta_we) status_mem[wr_addr[STA_AW-1:0]] <= wr_data;
    sta_rdata <= status_mem[area_addr[STA_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (set_we) settings_mem[wr_addr[SET_AW-1:0]] <= wr_data;
    set_rdata <= settings_mem[area_addr[SET_AW-1:0]];
  end

  assign area_rdata = is_status ? sta_rdata : set_rdata;

  // Reply assembly.
  logic [7:0]  hdr_byte;
  logic [7:0]  out_byte;
  logic [15:0] reply_sum;
  logic [15:0] reply_csum;
  logic        sum_add;
  logic        tx_valid;
  logic [7:0]  tx_data;
  logic        tx_last;

  always_comb begin
    case (cnt[2:0])
      HDR_SYNC0:  hdr_byte = SYNC0;
      HDR_SYNC1:  hdr_byte = SYNC1;
      HDR_LENGTH: hdr_byte = MIN_LENGTH + read_size;
      HDR_ADDR:   hdr_byte = reply_addr;
      HDR_MODE:   hdr_byte = frame_mode;
      HDR_OFFSET: hdr_byte = frame_offset;
      default:    hdr_byte = 8'd0;
    endcase
  end

  assign reply_csum = reply_sum ^ SUM_INVERT;

  always_comb begin
    case (cmd.out_sel)
      OSEL_HDR:  out_byte = hdr_byte;
      OSEL_DATA: out_byte = area_rdata;
      OSEL_CSL:  out_byte = reply_csum[7:0];
      OSEL_CSH:  out_byte = reply_csum[15:8];
      default:   out_byte = 8'd0;
    endcase
  end

  assign sum_add = (cmd.out_sel == OSEL_DATA) ||
                   (cmd.out_sel == OSEL_HDR && cnt >= CNT_W'(HDR_LENGTH));

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_sel == OSEL_HDR && cnt == CNT_W'(HDR_SYNC0)) begin
        reply_sum <= '0;
      end else if (sum_add) begin
        reply_sum <= reply_sum + {8'd0, out_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (cmd.out_load) begin
      tx_valid <= 1'b1;
    end else if (tx.ready) begin
      tx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      tx_data <= out_byte;
      tx_last <= (cmd.out_sel == OSEL_CSH);
    end
  end

  assign st.out_free      = !tx_valid || tx.ready;
  assign tx.valid         = tx_valid;
  assign tx.tx_byte       = tx_data;
  assign tx.last_of_reply = tx_last;

endmodule

[sv/serial_frame_register_responder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_register_responder
// Deframes register access requests from a serial byte stream and answers
// reads with reply frames; writes go to the status or settings memory.
// ----------------------------------------------------------------------------
// Received bytes and ticks are taken one per cycle while no request is served.
// A read reply passes the request check, then loads its header, data and two checksum
// bytes into the output register; input stays held off until the last one is loaded.
// A write holds input off while each payload byte is read from the buffer and then stored.
// Reset is synchronous; afterwards a clearing sweep over max(STATUS_BYTES,
// SETTINGS_BYTES) addresses zeroes both memories before the first byte is taken.
`include "assert_macros.svh"

module serial_frame_register_responder import sfrr_pkg::*; #(
  parameter int MAX_PAYLOAD    = 32,
  parameter int STATUS_BYTES   = 256,
  parameter int SETTINGS_BYTES = 128
) (
  input  logic      clk,
  input  logic      rst,
  sfrr_rx_if.sink   rx,
  sfrr_tx_if.source tx,
  sfrr_cfg_if.sink  cfg
);

  // The controller owns sequencing and the receive-side ready; the datapath
  // holds all other registers, the memories and the transmit output register. They talk
  // only through the command and status structs below.
  sfrr_cmd_t    cmd;
  sfrr_status_t st;

  sfrr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .rx_ready (rx.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Configuration transactions are always accepted; they are expected only
  // while the block is idle, so no interlock with a frame in progress exists.
  sfrr_dp #(
    .MAX_PAYLOAD    (MAX_PAYLOAD),
    .STATUS_BYTES   (STATUS_BYTES),
    .SETTINGS_BYTES (SETTINGS_BYTES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .func    (rx.func),
    .rx_byte (rx.rx_byte),
    .cfg     (cfg),
    .tx      (tx),
    .cmd     (cmd),
    .st      (st)
  );

  // A reply byte may only be loaded when the output register is empty or is
  // being taken in the same cycle; otherwise a pending transaction is lost.
  `SFRR_ASSERT_IMPLY(a_load_when_free, cmd.out_load, st.out_free, "reply byte overwrote a pending transaction")

  // No receive transaction may be taken while memories are swept, written or
  // read for a reply.
  `SFRR_ASSERT_IMPLY(a_no_rx_while_busy, cmd.out_load || cmd.area_wr || cmd.clear_en, !rx.ready, "receive channel open while a request is served")

  // The final checksum byte of a frame hands control to the request check.
  `SFRR_ASSERT_NEXT(a_final_closes_rx, cmd.accept && st.rx_final, !rx.ready, "receive channel stayed open after a complete frame")

endmodule
